[sv/iirlp_pkg.sv]
package iirlp_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 32;
    localparam int DELAY_BITS  = 48;
    localparam int DELAY_FRAC  = 16;
    localparam int COEF_FRAC   = 28;
    localparam int DEPTH       = 3;
    localparam int NUM_COEFS   = 2 * DEPTH + 1;
    localparam int HALF_BITS   = DELAY_BITS - DELAY_FRAC;
    localparam int MUL_A_BITS  = HALF_BITS + 1;
    localparam int PROD_BITS   = MUL_A_BITS + COEF_BITS;
    localparam int FULL_BITS   = DELAY_BITS + COEF_BITS;
    localparam int SCALED_BITS = FULL_BITS - COEF_FRAC;
    localparam int ACC_BITS    = SCALED_BITS + 4;
    localparam int YQ_BITS     = ACC_BITS - DELAY_FRAC;
    localparam int ADDR_BITS   = $clog2(NUM_COEFS);
    localparam int STEP_BITS   = 5;

    typedef logic [ADDR_BITS-1:0] t_coef_idx;
    typedef logic [STEP_BITS-1:0] t_step;

    localparam t_coef_idx COEF_DEN_OLDEST  = 3'd0;
    localparam t_coef_idx COEF_DEN_MIDDLE  = 3'd1;
    localparam t_coef_idx COEF_DEN_NEWEST  = 3'd2;
    localparam t_coef_idx COEF_NUM_OLDEST  = 3'd3;
    localparam t_coef_idx COEF_NUM_MIDDLE  = 3'd4;
    localparam t_coef_idx COEF_NUM_NEWEST  = 3'd5;
    localparam t_coef_idx COEF_NUM_CURRENT = 3'd6;

    localparam logic signed [COEF_BITS-1:0] COEF_RESET [NUM_COEFS] = '{
        -32'sd236736284, 32'sd739948213, -32'sd771584862,
        32'sd0, 32'sd0, 32'sd0, 32'sd62532
    };

    localparam t_step STEP_IDLE = 5'd0;
    localparam t_step STEP_DONE = 5'd16;

    typedef enum logic [1:0] {OPND_W0, OPND_W1, OPND_W2, OPND_WNEW} t_opnd;
    typedef enum logic [1:0] {WB_NONE, WB_SAVE, WB_ADD_FB, WB_ADD_Y} t_wb;
    typedef enum logic [1:0] {ACT_NONE, ACT_LOAD, ACT_WNEW, ACT_DONE} t_act;
    typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT} t_jmp;

    typedef struct packed {
        logic hi_half;
        logic save;
    } t_mul_ctl;

    typedef struct packed {
        t_opnd     opnd;
        logic      hi_half;
        t_coef_idx coef;
        t_wb       wb;
        t_act      act;
        t_jmp      jmp;
        t_step     target;
    } t_uop;

    function automatic t_uop uop_mul(input t_opnd opnd, input logic hi_half,
                                     input t_coef_idx coef, input t_wb wb);
        t_uop u;
        u.opnd    = opnd;
        u.hi_half = hi_half;
        u.coef    = coef;
        u.wb      = wb;
        u.act     = ACT_NONE;
        u.jmp     = JMP_NEXT;
        u.target  = STEP_IDLE;
        return u;
    endfunction

    // Each product takes two multiplier passes: upper half, then lower half.
    // The write-back field acts on the product issued one step earlier.
    function automatic t_uop uop_rom(input t_step pc);
        t_uop u;
        u = uop_mul(OPND_W0, 1'b0, COEF_DEN_OLDEST, WB_NONE);
        case (pc)
            5'd0: begin
                u.act = ACT_LOAD;
                u.jmp = JMP_WAIT_IN;
            end
            5'd1:  u = uop_mul(OPND_W0,   1'b1, COEF_DEN_OLDEST,  WB_NONE);
            5'd2:  u = uop_mul(OPND_W0,   1'b0, COEF_DEN_OLDEST,  WB_SAVE);
            5'd3:  u = uop_mul(OPND_W1,   1'b1, COEF_DEN_MIDDLE,  WB_ADD_FB);
            5'd4:  u = uop_mul(OPND_W1,   1'b0, COEF_DEN_MIDDLE,  WB_SAVE);
            5'd5:  u = uop_mul(OPND_W2,   1'b1, COEF_DEN_NEWEST,  WB_ADD_FB);
            5'd6:  u = uop_mul(OPND_W2,   1'b0, COEF_DEN_NEWEST,  WB_SAVE);
            5'd7:  u = uop_mul(OPND_W0,   1'b1, COEF_NUM_OLDEST,  WB_ADD_FB);
            5'd8: begin
                u = uop_mul(OPND_W0, 1'b0, COEF_NUM_OLDEST, WB_SAVE);
                u.act = ACT_WNEW;
            end
            5'd9:  u = uop_mul(OPND_W1,   1'b1, COEF_NUM_MIDDLE,  WB_ADD_Y);
            5'd10: u = uop_mul(OPND_W1,   1'b0, COEF_NUM_MIDDLE,  WB_SAVE);
            5'd11: u = uop_mul(OPND_W2,   1'b1, COEF_NUM_NEWEST,  WB_ADD_Y);
            5'd12: u = uop_mul(OPND_W2,   1'b0, COEF_NUM_NEWEST,  WB_SAVE);
            5'd13: u = uop_mul(OPND_WNEW, 1'b1, COEF_NUM_CURRENT, WB_ADD_Y);
            5'd14: u = uop_mul(OPND_WNEW, 1'b0, COEF_NUM_CURRENT, WB_SAVE);
            5'd15: u = uop_mul(OPND_W0,   1'b0, COEF_DEN_OLDEST,  WB_ADD_Y);
            5'd16: begin
                u.act    = ACT_DONE;
                u.jmp    = JMP_WAIT_OUT;
                u.target = STEP_IDLE;
            end
            default: begin
                u.jmp    = JMP_WAIT_OUT;
                u.target = STEP_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

[sv/iirlp_mul.sv]
module iirlp_mul (
    input  logic                                        i_clk,
    input  iirlp_pkg::t_mul_ctl                         i_ctl,
    input  logic signed [iirlp_pkg::DELAY_BITS-1:0]     i_operand,
    input  logic signed [iirlp_pkg::COEF_BITS-1:0]      i_coef,
    output logic signed [iirlp_pkg::SCALED_BITS-1:0]    o_scaled
);
    import iirlp_pkg::*;

    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [PROD_BITS-1:0]  r_part;
    logic signed [FULL_BITS-1:0]  full;

    always_comb begin
        if (i_ctl.hi_half) begin
            mul_a = {i_operand[DELAY_BITS-1], i_operand[DELAY_BITS-1:DELAY_FRAC]};
        end else begin
            mul_a = {{(MUL_A_BITS-DELAY_FRAC){1'b0}}, i_operand[DELAY_FRAC-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * i_coef;
        if (i_ctl.save) begin
            r_part <= r_prod;
        end
    end

    always_comb begin
        full = {r_part[FULL_BITS-DELAY_FRAC-1:0], {DELAY_FRAC{1'b0}}}
             + {{(FULL_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
    end

    assign o_scaled = full[FULL_BITS-1:COEF_FRAC];

endmodule

[sv/iir_lowpass_third_order.sv]
// Third-order IIR low-pass filter, direct form II, fixed point.
// Input channel i_s_*: one signed 16-bit sample per transaction.
// Output channel o_m_*: one filtered sample per input sample, with a
// saturation flag in tuser that is set when the new delay value or the
// output was clipped.
// Coefficients are seven signed Q3.28 registers written through i_cfg_*,
// index 0 to 2 feedback (oldest to newest), 3 to 6 feedforward; index 7 is
// ignored. Write them only while the filter is idle.
// A microcoded sequencer drives one shared 33x32 multiplier; every product
// of a 48-bit delay value and a coefficient takes two passes, and seven
// products are formed per sample. The result is loaded into the output
// register at the final step, and the next sample is accepted once the
// sequencer is back at idle; no sample is accepted while one is in progress.
// A synchronous reset clears the delay line and loads default coefficients
// (100 Hz Butterworth poles at 10 kHz sampling, current input tap only).
// If the receiver stalls, the result waits in the output register and the
// sequencer holds at its last step until the register is free.
module iir_lowpass_third_order (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] sample_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] sample_out
    output logic        o_m_tuser,   // [0] saturated
    input  logic        i_cfg_we,
    input  logic [iirlp_pkg::ADDR_BITS-1:0] i_cfg_addr,
    input  logic [iirlp_pkg::COEF_BITS-1:0] i_cfg_data
);
    import iirlp_pkg::*;

    t_step r_pc;
    t_step n_pc;
    t_uop  uop;

    logic signed [COEF_BITS-1:0]   r_coef [NUM_COEFS];
    logic signed [DELAY_BITS-1:0]  r_w [DEPTH];
    logic signed [DELAY_BITS-1:0]  r_wnew;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [ACC_BITS-1:0]    r_fb;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic                          r_clip;
    logic                          r_out_valid;
    logic [SAMPLE_BITS-1:0]        r_out_data;
    logic                          r_out_sat;

    logic                          in_accept;
    logic                          out_free;
    logic                          done;
    logic signed [DELAY_BITS-1:0]  operand;
    logic signed [COEF_BITS-1:0]   coef;
    t_mul_ctl                      mul_ctl;
    logic signed [SCALED_BITS-1:0] scaled;
    logic signed [ACC_BITS-1:0]    scaled_ext;
    logic signed [ACC_BITS-1:0]    diff;
    logic                          diff_ovf;
    logic signed [DELAY_BITS-1:0]  wnew_sat;
    logic signed [YQ_BITS-1:0]     yq;
    logic                          y_ovf;
    logic [SAMPLE_BITS-1:0]        y_sat;

    assign uop        = uop_rom(r_pc);
    assign o_s_tready = (uop.jmp == JMP_WAIT_IN);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign done       = (uop.act == ACT_DONE) && out_free;

    always_comb begin
        case (uop.jmp)
            JMP_NEXT:     n_pc = r_pc + 1'b1;
            JMP_WAIT_IN:  n_pc = in_accept ? r_pc + 1'b1 : r_pc;
            JMP_WAIT_OUT: n_pc = out_free ? uop.target : r_pc;
            default:      n_pc = STEP_IDLE;
        endcase
    end

    always_comb begin
        case (uop.opnd)
            OPND_W0:   operand = r_w[0];
            OPND_W1:   operand = r_w[1];
            OPND_W2:   operand = r_w[2];
            OPND_WNEW: operand = r_wnew;
            default:   operand = r_wnew;
        endcase
    end

    assign coef            = r_coef[uop.coef];
    assign mul_ctl.hi_half = uop.hi_half;
    assign mul_ctl.save    = (uop.wb == WB_SAVE);

    iirlp_mul u_mul (
        .i_clk     (i_clk),
        .i_ctl     (mul_ctl),
        .i_operand (operand),
        .i_coef    (coef),
        .o_scaled  (scaled)
    );

    assign scaled_ext = {{(ACC_BITS-SCALED_BITS){scaled[SCALED_BITS-1]}}, scaled};

    always_comb begin
        diff = {{(ACC_BITS-SAMPLE_BITS-DELAY_FRAC){r_x[SAMPLE_BITS-1]}}, r_x,
                {DELAY_FRAC{1'b0}}} - r_fb;
        diff_ovf = (diff[ACC_BITS-1:DELAY_BITS-1] != {(ACC_BITS-DELAY_BITS+1){1'b0}})
                && (diff[ACC_BITS-1:DELAY_BITS-1] != {(ACC_BITS-DELAY_BITS+1){1'b1}});
        if (!diff_ovf) begin
            wnew_sat = diff[DELAY_BITS-1:0];
        end else if (diff[ACC_BITS-1]) begin
            wnew_sat = {1'b1, {(DELAY_BITS-1){1'b0}}};
        end else begin
            wnew_sat = {1'b0, {(DELAY_BITS-1){1'b1}}};
        end
    end

    always_comb begin
        yq = r_acc[ACC_BITS-1:DELAY_FRAC];
        y_ovf = (yq[YQ_BITS-1:SAMPLE_BITS-1] != {(YQ_BITS-SAMPLE_BITS+1){1'b0}})
             && (yq[YQ_BITS-1:SAMPLE_BITS-1] != {(YQ_BITS-SAMPLE_BITS+1){1'b1}});
        if (!y_ovf) begin
            y_sat = yq[SAMPLE_BITS-1:0];
        end else if (yq[YQ_BITS-1]) begin
            y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_COEFS; k++) begin
                r_coef[k] <= COEF_RESET[k];
            end
            for (int k = 0; k < DEPTH; k++) begin
                r_w[k] <= '0;
            end
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we && (i_cfg_addr inside {[COEF_DEN_OLDEST:COEF_NUM_CURRENT]})) begin
                r_coef[i_cfg_addr] <= i_cfg_data;
            end
            if (done) begin
                r_out_valid <= 1'b1;
                for (int k = 0; k < DEPTH - 1; k++) begin
                    r_w[k] <= r_w[k+1];
                end
                r_w[DEPTH-1] <= r_wnew;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x    <= i_s_tdata;
            r_fb   <= '0;
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else begin
            if (uop.wb == WB_ADD_FB) begin
                r_fb <= r_fb + scaled_ext;
            end
            if (uop.wb == WB_ADD_Y) begin
                r_acc <= r_acc + scaled_ext;
            end
            if (uop.act == ACT_WNEW) begin
                r_wnew <= wnew_sat;
                r_clip <= diff_ovf;
            end
        end
        if (done) begin
            r_out_data <= y_sat;
            r_out_sat  <= r_clip || y_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_pc == STEP_IDLE + 1'b1))
        else $error("sequencer did not start after an input transaction");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc != STEP_IDLE) |-> !o_s_tready)
        else $error("input ready while a sample is in progress");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= STEP_DONE)
        else $error("step counter out of program range");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_pc) == STEP_DONE))
        else $error("result appeared outside the final step");

endmodule
